>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker of this project.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

	localparam int CNT_W = 6;
	localparam int VAL_W = 32;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_INS = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	typedef struct packed {
		logic [1:0]              op;
		logic [CNT_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                    status;
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_W-1:0]        length_now;
	} rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic [CNT_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/pli_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module pli_decode #(
	parameter int CAPACITY = 32
) (
	input  wire pli_pkg::req_t              req,
	input  wire logic                       go,
	input  wire logic [pli_pkg::CNT_W-1:0]  count,
	output pli_pkg::cmd_t                   cmd,
	output logic                            ok,
	output logic                            rd_sel,
	output logic [pli_pkg::CNT_W-1:0]       count_next
);

	logic                    pos_nz;
	logic                    rd_ok;
	logic                    ins_ok;
	logic [pli_pkg::CNT_W:0] count_p1;

	assign pos_nz   = (req.position != '0);
	assign count_p1 = {1'b0, count} + (pli_pkg::CNT_W+1)'(1);
	assign rd_ok    = pos_nz && (req.position <= count);
	assign ins_ok   = (count < pli_pkg::CNT_W'(CAPACITY)) && pos_nz
		&& ({1'b0, req.position} <= count_p1);

	always_comb begin
		ok         = 1'b0;
		rd_sel     = 1'b0;
		count_next = count;
		case (req.op)
			pli_pkg::OP_GET: begin
				ok     = rd_ok;
				rd_sel = rd_ok;
			end
			pli_pkg::OP_INS: begin
				ok = ins_ok;
				if (ins_ok) begin
					count_next = count_p1[pli_pkg::CNT_W-1:0];
				end
			end
			pli_pkg::OP_DEL: begin
				ok     = rd_ok;
				rd_sel = rd_ok;
				if (rd_ok) begin
					count_next = count - pli_pkg::CNT_W'(1);
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Fire the shift only for a transaction that really changes the list.
	assign cmd.ins   = go && ins_ok && (req.op == pli_pkg::OP_INS);
	assign cmd.del   = go && rd_ok && (req.op == pli_pkg::OP_DEL);
	assign cmd.pos   = req.position;
	assign cmd.value = req.value;

endmodule

`default_nettype wire

>>> hw/rtl/pli_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pli_cell #(
	parameter int CELL_POS = 1
) (
	input  wire logic                              clk,
	input  wire pli_pkg::cmd_t                     cmd,
	input  wire logic signed [pli_pkg::VAL_W-1:0]  left,
	input  wire logic signed [pli_pkg::VAL_W-1:0]  right,
	output logic signed [pli_pkg::VAL_W-1:0]       entry
);

	localparam logic [pli_pkg::CNT_W-1:0] MY_POS = pli_pkg::CNT_W'(CELL_POS);

	logic signed [pli_pkg::VAL_W-1:0] entry_q;

	// Insert: cells above the slot take the left neighbor, the slot takes the value.
	// Delete: the slot and cells above take the right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_POS > cmd.pos) begin
				entry_q <= left;
			end else if (MY_POS == cmd.pos) begin
				entry_q <= cmd.value;
			end
		end else if (cmd.del) begin
			if (MY_POS >= cmd.pos) begin
				entry_q <= right;
			end
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_insert_delete.sv
// Channel | Dir | Handshake         | Payload
// --------+-----+-------------------+-----------------------------------------
// req     | in  | req_valid / stall | pli_pkg::req_t {op, position, value}
// rsp     | out | rsp_valid / stall | pli_pkg::rsp_t {status, read_value,
//         |     |                   |                 length_now}
//
// Each accepted request is decoded and the cell chain shifts at the same edge;
// the result is registered and appears in the cycle after acceptance, and
// throughput is one transaction per cycle unless rsp_stall holds a result back.
// Reset clears the length and the result valid flag; cell contents stay
// undefined and are never read beyond the length.
// req_stall follows rsp_stall while a result is held in the output register.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete #(
	parameter int CAPACITY = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pli_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pli_pkg::rsp_t      rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [pli_pkg::CNT_W-1:0]        count_q;
	logic [pli_pkg::CNT_W-1:0]        count_next;
	logic                             rsp_valid_q;
	pli_pkg::rsp_t                    rsp_q;
	pli_pkg::cmd_t                    cmd;
	logic                             accept;
	logic                             ok;
	logic                             rd_sel;
	logic [pli_pkg::CNT_W-1:0]        rd_pos_m1;
	logic [IDX_W-1:0]                 rd_idx;
	logic signed [pli_pkg::VAL_W-1:0] ent [CAPACITY];

	// Hold the request while a finished result still waits downstream.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	pli_decode #(
		.CAPACITY(CAPACITY)
	) u_decode (
		.req       (req),
		.go        (accept),
		.count     (count_q),
		.cmd       (cmd),
		.ok        (ok),
		.rd_sel    (rd_sel),
		.count_next(count_next)
	);

	// Chain of cells: cell k holds list position k+1 and talks to its neighbors.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [pli_pkg::VAL_W-1:0] left_in;
		logic signed [pli_pkg::VAL_W-1:0] right_in;

		if (k == 0) begin : g_first
			assign left_in = req.value;
		end else begin : g_mid_l
			assign left_in = ent[k-1];
		end

		if (k == CAPACITY-1) begin : g_last
			assign right_in = ent[k];
		end else begin : g_mid_r
			assign right_in = ent[k+1];
		end

		pli_cell #(
			.CELL_POS(k + 1)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.left (left_in),
			.right(right_in),
			.entry(ent[k])
		);
	end

	// Read before the shift: a delete returns the value it removes.
	assign rd_pos_m1 = req.position - pli_pkg::CNT_W'(1);
	assign rd_idx    = rd_pos_m1[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status     <= !ok;
			rsp_q.read_value <= rd_sel ? ent[rd_idx] : '0;
			rsp_q.length_now <= count_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> hw/rtl/pli_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pli_checker #(
	parameter int CAPACITY = 32
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire pli_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire pli_pkg::rsp_t rsp
);

	`CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
	`CHK_NEXT(a_one_cycle, req_valid && !req_stall, rsp_valid, "accepted request gave no result")
	`CHK_SAME(a_backpressure, rsp_valid && rsp_stall, req_stall, "request taken over a blocked result")
	`CHK_SAME(a_err_zero, rsp_valid && rsp.status, rsp.read_value == 0, "error result carries data")
	`CHK_SAME(a_len_cap, rsp_valid, rsp.length_now <= CAPACITY, "length above capacity")

endmodule

bind positional_list_insert_delete pli_checker #(.CAPACITY(CAPACITY)) u_pli_checker (.*);

`default_nettype wire
